// ===== hdl/ctcu_pkg.sv =====
`timescale 1ns / 1ps
package ctcu_pkg;

    localparam int SLOT_W    = 3;
    localparam int NUM_SLOTS = 8;
    localparam int VAL_W     = 16;
    localparam int CNT_W     = 10;
    localparam int STAT_W    = 4;
    localparam int CFG_IDX_W = 4;
    localparam int ACC_W     = 20;

    localparam logic [CNT_W-1:0]     STOCK_MAX = 10'd1023;
    localparam logic [CFG_IDX_W-1:0] NUM_CFG   = 4'd8;

    typedef logic [NUM_SLOTS-1:0][VAL_W-1:0] t_coin_arr;
    typedef logic [NUM_SLOTS-1:0][CNT_W-1:0] t_stock_arr;

    localparam t_coin_arr COIN_RESET = {16'd1000, 16'd500, 16'd200, 16'd100,
                                        16'd50, 16'd20, 16'd10, 16'd5};

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_LOAD   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OWING     = 4'd0;
    localparam logic [STAT_W-1:0] ST_PAID      = 4'd1;
    localparam logic [STAT_W-1:0] ST_CHANGE    = 4'd2;
    localparam logic [STAT_W-1:0] ST_INVALID   = 4'd3;
    localparam logic [STAT_W-1:0] ST_CANCELLED = 4'd4;
    localparam logic [STAT_W-1:0] ST_TOO_MANY  = 4'd5;
    localparam logic [STAT_W-1:0] ST_NO_CHANGE = 4'd6;
    localparam logic [STAT_W-1:0] ST_LOADED    = 4'd7;
    localparam logic [STAT_W-1:0] ST_IGNORED   = 4'd8;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REFUND = 5'b00010,
        S_BANK   = 5'b00100,
        S_CHECK  = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    typedef struct packed {
        logic              load;
        logic [SLOT_W-1:0] ld_slot;
        logic [CNT_W-1:0]  ld_val;
        logic              bank;
        logic [SLOT_W-1:0] bank_slot;
        logic              start;
        logic [VAL_W-1:0]  change;
        logic              step;
        logic              commit;
    } t_walk_cmd;

    typedef struct packed {
        logic              done;
        logic              ok;
        logic              pay;
        logic              last;
        logic [SLOT_W-1:0] slot;
        logic [VAL_W-1:0]  value;
    } t_walk_st;

endpackage

// ===== hdl/ctcu_walk.sv =====
`timescale 1ns / 1ps
module ctcu_walk #(
    parameter int DENOM_SLOTS      = 8,
    parameter int MAX_CHANGE_COINS = 63
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ctcu_pkg::t_coin_arr  i_coin,
    input  ctcu_pkg::t_walk_cmd  i_cmd,
    output ctcu_pkg::t_walk_st   o_st
);

    localparam int NW = $clog2(MAX_CHANGE_COINS + 1);

    ctcu_pkg::t_stock_arr r_stock;
    ctcu_pkg::t_stock_arr r_trial;
    logic [ctcu_pkg::SLOT_W-1:0] r_slot;
    logic [ctcu_pkg::VAL_W-1:0]  r_remain;
    logic [NW-1:0]               r_n;

    logic [ctcu_pkg::VAL_W-1:0] v;
    logic can_pay, full;

    always_comb begin
        v       = i_coin[r_slot];
        can_pay = (r_remain != '0) && (v != '0) && (v <= r_remain) && (r_trial[r_slot] != '0);
        full    = r_n >= NW'(MAX_CHANGE_COINS);
        o_st.ok    = (r_remain == '0);
        o_st.done  = (r_remain == '0) || (can_pay && full) || (!can_pay && r_slot == '0);
        o_st.pay   = can_pay && !full;
        o_st.last  = (r_remain == v);
        o_st.slot  = r_slot;
        o_st.value = v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stock  <= '0;
            r_slot   <= '0;
            r_remain <= '0;
            r_n      <= '0;
        end else begin
            if (i_cmd.load) begin
                r_stock[i_cmd.ld_slot] <= i_cmd.ld_val;
            end
            if (i_cmd.bank && r_stock[i_cmd.bank_slot] != ctcu_pkg::STOCK_MAX) begin
                r_stock[i_cmd.bank_slot] <= r_stock[i_cmd.bank_slot] + 1'b1;
            end
            if (i_cmd.commit) begin
                r_stock <= r_trial;
            end
            if (i_cmd.start) begin
                r_trial  <= r_stock;
                r_slot   <= ctcu_pkg::SLOT_W'(DENOM_SLOTS - 1);
                r_remain <= i_cmd.change;
                r_n      <= '0;
            end else if (i_cmd.step && !o_st.done) begin
                if (can_pay) begin
                    r_trial[r_slot] <= r_trial[r_slot] - 1'b1;
                    r_remain        <= r_remain - v;
                    r_n             <= r_n + 1'b1;
                end else begin
                    r_slot <= r_slot - 1'b1;
                end
            end
        end
    end

endmodule

// ===== hdl/coin_tender_and_change_unit.sv =====
`timescale 1ns / 1ps
// Vending cash unit. Start, load, invalid-coin and ignored beats are answered
// straight from idle. A cancel (or a sale ending on too many coins or no
// change) sums the tendered coins one per cycle. Exact payment banks one
// tendered coin per cycle. Overpay runs the greedy change walk twice on one
// shared compare/subtract unit, one coin or one slot step per cycle (check
// pass, then pay pass emitting one change beat per coin, which waits while the
// output register is busy), then banks. Input ready is low until an item is
// fully done and the output register is free.
module coin_tender_and_change_unit #(
    parameter int DENOM_SLOTS      = 8,
    parameter int MAX_TENDERED     = 10,
    parameter int MAX_CHANGE_COINS = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_amount,
    input  logic [2:0]  i_stock_slot,
    input  logic [9:0]  i_stock_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_status,
    output logic [15:0] o_owing_left,
    output logic [15:0] o_change_coin,
    output logic [2:0]  o_change_slot,
    output logic [15:0] o_refund_total,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_TENDERED + 1);
    localparam int TW = (MAX_TENDERED > 1) ? $clog2(MAX_TENDERED) : 1;

    ctcu_pkg::t_state r_state, n_state;
    ctcu_pkg::t_coin_arr r_coin;
    logic                          r_sale, n_sale;
    logic [ctcu_pkg::VAL_W-1:0]    r_owing, n_owing;
    logic [CW-1:0]                 r_count, n_count;
    logic [CW-1:0]                 r_idx, n_idx;
    logic [ctcu_pkg::ACC_W-1:0]    r_acc, n_acc;
    logic [ctcu_pkg::STAT_W-1:0]   r_code, n_code;
    logic                          r_exact, n_exact;
    logic [ctcu_pkg::VAL_W-1:0]    r_change, n_change;
    logic [ctcu_pkg::SLOT_W-1:0]   r_tend [MAX_TENDERED];

    ctcu_pkg::t_walk_cmd cmd;
    ctcu_pkg::t_walk_st  ws;

    logic                        out_free, hit, tw_en, em_v;
    logic [ctcu_pkg::SLOT_W-1:0] hit_slot, idx_slot;
    logic [ctcu_pkg::STAT_W-1:0] em_status;
    logic [15:0]                 em_owing, em_coin, em_refund;
    logic [2:0]                  em_slot;
    logic                        em_last;

    assign out_free    = !o_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ctcu_pkg::S_IDLE) && out_free;
    assign o_cfg_ready = 1'b1;
    assign idx_slot    = r_tend[r_idx[TW-1:0]];

    // lowest matching slot wins
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = DENOM_SLOTS - 1; i >= 0; i--) begin
            if (r_coin[i] != '0 && r_coin[i] == i_amount) begin
                hit      = 1'b1;
                hit_slot = ctcu_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_sale    = r_sale;
        n_owing   = r_owing;
        n_count   = r_count;
        n_idx     = r_idx;
        n_acc     = r_acc;
        n_code    = r_code;
        n_exact   = r_exact;
        n_change  = r_change;
        tw_en     = 1'b0;
        cmd       = '0;
        em_v      = 1'b0;
        em_status = ctcu_pkg::ST_IGNORED;
        em_owing  = '0;
        em_coin   = '0;
        em_slot   = '0;
        em_refund = '0;
        em_last   = 1'b1;
        case (r_state)
            ctcu_pkg::S_IDLE: begin
                if (i_in_valid && out_free) begin
                    em_v     = 1'b1;
                    em_owing = r_owing;
                    case (i_operation)
                        ctcu_pkg::OP_LOAD: begin
                            if ({1'b0, i_stock_slot} < 4'(DENOM_SLOTS)) begin
                                em_status   = ctcu_pkg::ST_LOADED;
                                cmd.load    = 1'b1;
                                cmd.ld_slot = i_stock_slot;
                                cmd.ld_val  = i_stock_value;
                            end
                        end
                        ctcu_pkg::OP_START: begin
                            if (!r_sale) begin
                                if (i_amount == '0) begin
                                    em_status = ctcu_pkg::ST_PAID;
                                    em_owing  = '0;
                                end else begin
                                    em_status = ctcu_pkg::ST_OWING;
                                    em_owing  = i_amount;
                                    n_sale    = 1'b1;
                                    n_owing   = i_amount;
                                    n_count   = '0;
                                end
                            end
                        end
                        ctcu_pkg::OP_CANCEL: begin
                            if (r_sale) begin
                                em_v    = 1'b0;
                                n_code  = ctcu_pkg::ST_CANCELLED;
                                n_idx   = '0;
                                n_acc   = '0;
                                n_state = ctcu_pkg::S_REFUND;
                            end
                        end
                        ctcu_pkg::OP_INSERT: begin
                            if (r_sale && !hit) begin
                                em_status = ctcu_pkg::ST_INVALID;
                            end else if (r_sale) begin
                                tw_en   = 1'b1;
                                n_count = r_count + 1'b1;
                                n_idx   = '0;
                                n_acc   = '0;
                                if (i_amount < r_owing) begin
                                    n_owing = r_owing - i_amount;
                                    if (n_count >= CW'(MAX_TENDERED)) begin
                                        em_v    = 1'b0;
                                        n_code  = ctcu_pkg::ST_TOO_MANY;
                                        n_state = ctcu_pkg::S_REFUND;
                                    end else begin
                                        em_status = ctcu_pkg::ST_OWING;
                                        em_owing  = n_owing;
                                    end
                                end else if (i_amount == r_owing) begin
                                    em_v    = 1'b0;
                                    n_exact = 1'b1;
                                    n_state = ctcu_pkg::S_BANK;
                                end else begin
                                    em_v       = 1'b0;
                                    n_exact    = 1'b0;
                                    n_change   = i_amount - r_owing;
                                    cmd.start  = 1'b1;
                                    cmd.change = n_change;
                                    n_state    = ctcu_pkg::S_CHECK;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ctcu_pkg::S_REFUND: begin
                if (r_idx == r_count) begin
                    if (out_free) begin
                        em_v      = 1'b1;
                        em_status = r_code;
                        em_refund = (r_acc > ctcu_pkg::ACC_W'(16'hFFFF)) ? 16'hFFFF : r_acc[15:0];
                        n_sale    = 1'b0;
                        n_owing   = '0;
                        n_count   = '0;
                        n_state   = ctcu_pkg::S_IDLE;
                    end
                end else begin
                    n_acc = r_acc + ctcu_pkg::ACC_W'(r_coin[idx_slot]);
                    n_idx = r_idx + 1'b1;
                end
            end
            ctcu_pkg::S_BANK: begin
                if (r_idx == r_count) begin
                    if (!r_exact || out_free) begin
                        em_v      = r_exact;
                        em_status = ctcu_pkg::ST_PAID;
                        n_sale    = 1'b0;
                        n_owing   = '0;
                        n_count   = '0;
                        n_state   = ctcu_pkg::S_IDLE;
                    end
                end else begin
                    cmd.bank      = 1'b1;
                    cmd.bank_slot = idx_slot;
                    n_idx         = r_idx + 1'b1;
                end
            end
            ctcu_pkg::S_CHECK: begin
                if (ws.done) begin
                    if (ws.ok) begin
                        cmd.start  = 1'b1;
                        cmd.change = r_change;
                        n_state    = ctcu_pkg::S_EMIT;
                    end else begin
                        n_code  = ctcu_pkg::ST_NO_CHANGE;
                        n_state = ctcu_pkg::S_REFUND;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ctcu_pkg::S_EMIT: begin
                if (ws.done) begin
                    cmd.commit = 1'b1;
                    n_state    = ctcu_pkg::S_BANK;
                end else if (!ws.pay) begin
                    cmd.step = 1'b1;
                end else if (out_free) begin
                    cmd.step  = 1'b1;
                    em_v      = 1'b1;
                    em_status = ctcu_pkg::ST_CHANGE;
                    em_coin   = ws.value;
                    em_slot   = ws.slot;
                    em_last   = ws.last;
                end
            end
            default: n_state = ctcu_pkg::S_IDLE;
        endcase
    end

    ctcu_walk #(
        .DENOM_SLOTS      (DENOM_SLOTS),
        .MAX_CHANGE_COINS (MAX_CHANGE_COINS)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coin  (r_coin),
        .i_cmd   (cmd),
        .o_st    (ws)
    );

    always_ff @(posedge i_clk) begin
        if (tw_en) begin
            r_tend[r_count[TW-1:0]] <= hit_slot;
        end
        r_acc    <= n_acc;
        r_code   <= n_code;
        r_exact  <= n_exact;
        r_change <= n_change;
        r_idx    <= n_idx;
        if (em_v) begin
            o_status       <= em_status;
            o_owing_left   <= em_owing;
            o_change_coin  <= em_coin;
            o_change_slot  <= em_slot;
            o_refund_total <= em_refund;
            o_last         <= em_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ctcu_pkg::S_IDLE;
            r_coin      <= ctcu_pkg::COIN_RESET;
            r_sale      <= 1'b0;
            r_owing     <= '0;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sale  <= n_sale;
            r_owing <= n_owing;
            r_count <= n_count;
            if (i_cfg_valid && i_cfg_index < ctcu_pkg::NUM_CFG) begin
                r_coin[i_cfg_index[2:0]] <= i_cfg_data;
            end
            if (em_v) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule
